// ===== hdl/nperm_pkg.sv =====
`default_nettype none

package nperm_pkg;

   // input word opcodes
   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_ADVANCE = 1'b1;

   typedef struct packed {
      logic       op;
      logic [7:0] value;
      logic       last;
   } req_word_type;

   typedef struct packed {
      logic [7:0] elem;
      logic [3:0] position;
      logic       end_of_run;
      logic       done_res;
   } rsp_word_type;

endpackage

`default_nettype wire

// ===== hdl/nperm_ram.sv =====
`default_nettype none

// single write port, single read port, registered read data
module nperm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== hdl/next_permutation_generator.sv =====
// Next lexicographic permutation generator.
// req channel (req_valid / req_stall / req_word): a load word (op = load) writes one
// element at the load pointer; a word with last set fixes the sequence length and
// rewinds the pointer. Loads past MAX_LEN elements are dropped. An advance word
// (op = advance) rewrites the stored sequence into its next permutation in place.
// rsp channel (rsp_valid / rsp_stall / rsp_word): an advance yields one word per
// element, position 0 upwards, end_of_run on the last; with no next permutation a
// single word with done_res and end_of_run set, sequence untouched.
// Steps: loads are accepted back to back. An advance of length n runs the pivot
// scan, the successor scan, the swap, then ST_REV_RD_J, ST_REV_WR_I and ST_REV_WR_J
// for each pair reversed in the tail and ST_OUT_RD, ST_OUT_WAIT per element out.
// All of it is bound by the one read and one write port of the sequence RAM.
// req_stall is high for the whole of an advance; the final result word sits in the
// output register while the next item is already accepted.
// A stalled result word simply holds; the sequencer waits before reading the next
// element. Synchronous reset clears length, load pointer and output valid; the
// sequence store itself has no clear and is undefined until loaded.
`default_nettype none

module next_permutation_generator #(
   parameter int MAX_LEN    = 16,
   parameter int ELEM_WIDTH = 8
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire nperm_pkg::req_word_type req_word,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output nperm_pkg::rsp_word_type      rsp_word
);

   localparam int IW = $clog2(MAX_LEN);      // RAM address width
   localparam int CW = $clog2(MAX_LEN + 1);  // length / pointer width

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_K_FIRST,
      ST_K_SCAN,
      ST_L_SCAN,
      ST_SWAP_K,
      ST_REV_RD_J,
      ST_REV_WR_I,
      ST_REV_WR_J,
      ST_OUT_RD,
      ST_OUT_WAIT,
      ST_DONE_OUT
   } state_type;

   state_type state_ff, state_in;

   logic [CW-1:0]         len_ff, len_in;   // sequence length
   logic [CW-1:0]         lp_ff, lp_in;     // load pointer
   logic [IW-1:0]         i_ff, i_in;       // scan / reverse low index
   logic [IW-1:0]         j_ff, j_in;       // scan / reverse high index
   logic [IW-1:0]         k_ff, k_in;       // pivot
   logic [IW-1:0]         o_ff, o_in;       // output position
   logic [ELEM_WIDTH-1:0] prev_ff, prev_in; // right neighbour in pivot scan
   logic [ELEM_WIDTH-1:0] ak_ff, ak_in;     // pivot value
   logic [ELEM_WIDTH-1:0] al_ff, al_in;     // successor value
   logic [ELEM_WIDTH-1:0] tmp_ff, tmp_in;   // low element of a reverse pair
   logic                  rsp_valid_ff, rsp_valid_in;
   nperm_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic                  mem_wr_en;
   logic [IW-1:0]         mem_wr_addr;
   logic [ELEM_WIDTH-1:0] mem_wr_data;
   logic                  mem_rd_en;
   logic [IW-1:0]         mem_rd_addr;
   logic [ELEM_WIDTH-1:0] mem_rd_data;

   logic [ELEM_WIDTH+7:0] val_ext;
   logic [ELEM_WIDTH+7:0] rd_ext;
   logic [IW+3:0]         pos_ext;
   logic [IW-1:0]         lenm1;
   logic [CW-1:0]         lp_next;
   logic                  out_free;

   nperm_ram #(
      .WIDTH (ELEM_WIDTH),
      .DEPTH (MAX_LEN)
   ) u_seq_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // element widths other than eight: zero-extend then cut
   assign val_ext = {{ELEM_WIDTH{1'b0}}, req_word.value};
   assign rd_ext  = {8'd0, mem_rd_data};
   assign pos_ext = {4'd0, o_ff};
   assign lenm1   = IW'(len_ff - CW'(1));

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // output register empty, or emptied at this edge
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      lp_in        = lp_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      o_in         = o_ff;
      prev_in      = prev_ff;
      ak_in        = ak_ff;
      al_in        = al_ff;
      tmp_in       = tmp_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = '0;
      mem_wr_data  = '0;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = '0;
      lp_next      = lp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_word.op == nperm_pkg::OP_LOAD) begin
                  if (lp_ff < CW'(MAX_LEN)) begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = lp_ff[IW-1:0];
                     mem_wr_data = val_ext[ELEM_WIDTH-1:0];
                     lp_next     = lp_ff + CW'(1);
                  end
                  if (req_word.last) begin
                     len_in = lp_next;
                     lp_in  = '0;
                  end else begin
                     lp_in = lp_next;
                  end
               end else if (len_ff < CW'(2)) begin
                  state_in = ST_DONE_OUT;
               end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = lenm1;
                  i_in        = lenm1;
                  state_in    = ST_K_FIRST;
               end
            end
         end

         ST_K_FIRST: begin
            prev_in     = mem_rd_data;
            mem_rd_en   = 1'b1;
            mem_rd_addr = i_ff - IW'(1);
            i_in        = i_ff - IW'(1);
            state_in    = ST_K_SCAN;
         end

         // walk down looking for a[i] < a[i+1]
         ST_K_SCAN: begin
            if (mem_rd_data < prev_ff) begin
               k_in        = i_ff;
               ak_in       = mem_rd_data;
               mem_rd_en   = 1'b1;
               mem_rd_addr = lenm1;
               j_in        = lenm1;
               state_in    = ST_L_SCAN;
            end else if (i_ff == '0) begin
               state_in = ST_DONE_OUT;
            end else begin
               prev_in     = mem_rd_data;
               mem_rd_en   = 1'b1;
               mem_rd_addr = i_ff - IW'(1);
               i_in        = i_ff - IW'(1);
            end
         end

         // rightmost element above the pivot; always found by k+1
         ST_L_SCAN: begin
            if (ak_ff < mem_rd_data) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = j_ff;
               mem_wr_data = ak_ff;
               al_in       = mem_rd_data;
               i_in        = k_ff + IW'(1);
               j_in        = lenm1;
               state_in    = ST_SWAP_K;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = j_ff - IW'(1);
               j_in        = j_ff - IW'(1);
            end
         end

         ST_SWAP_K: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = k_ff;
            mem_wr_data = al_ff;
            if (i_ff < j_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = i_ff;
               state_in    = ST_REV_RD_J;
            end else begin
               o_in     = '0;
               state_in = ST_OUT_RD;
            end
         end

         ST_REV_RD_J: begin
            tmp_in      = mem_rd_data;
            mem_rd_en   = 1'b1;
            mem_rd_addr = j_ff;
            state_in    = ST_REV_WR_I;
         end

         ST_REV_WR_I: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = i_ff;
            mem_wr_data = mem_rd_data;
            state_in    = ST_REV_WR_J;
         end

         // second write of the pair overlaps the read of the next low element
         ST_REV_WR_J: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = j_ff;
            mem_wr_data = tmp_ff;
            i_in        = i_ff + IW'(1);
            j_in        = j_ff - IW'(1);
            if ((i_ff + IW'(1)) < (j_ff - IW'(1))) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = i_ff + IW'(1);
               state_in    = ST_REV_RD_J;
            end else begin
               o_in     = '0;
               state_in = ST_OUT_RD;
            end
         end

         ST_OUT_RD: begin
            if (out_free) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = o_ff;
               state_in    = ST_OUT_WAIT;
            end
         end

         ST_OUT_WAIT: begin
            rsp_valid_in           = 1'b1;
            rsp_word_in.elem       = rd_ext[7:0];
            rsp_word_in.position   = pos_ext[3:0];
            rsp_word_in.end_of_run = (o_ff == lenm1);
            rsp_word_in.done_res   = 1'b0;
            if (o_ff == lenm1) begin
               state_in = ST_IDLE;
            end else begin
               o_in     = o_ff + IW'(1);
               state_in = ST_OUT_RD;
            end
         end

         ST_DONE_OUT: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_word_in.elem       = '0;
               rsp_word_in.position   = '0;
               rsp_word_in.end_of_run = 1'b1;
               rsp_word_in.done_res   = 1'b1;
               state_in               = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      o_ff        <= o_in;
      prev_ff     <= prev_in;
      ak_ff       <= ak_in;
      al_ff       <= al_in;
      tmp_ff      <= tmp_in;
      rsp_word_ff <= rsp_word_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         lp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         lp_ff        <= lp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // no same-cycle read and write of one entry: the RAM gives no forwarding
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en && mem_rd_en |-> mem_wr_addr != mem_rd_addr)
      else $error("sequence RAM read and write hit the same entry");

   // successor scan never passes the pivot
   a_l_above_k: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_L_SCAN |-> j_ff > k_ff)
      else $error("successor scan reached the pivot");

   // a reverse pair is always ordered
   a_rev_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_REV_RD_J |-> i_ff < j_ff)
      else $error("tail reverse indices crossed");

   // length cannot move during an advance
   a_len_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |=> $stable(len_ff))
      else $error("length changed during an advance");

   // an exhausted word is always the end of its run
   a_done_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.done_res |-> rsp_word_ff.end_of_run)
      else $error("done word without end of run");

endmodule

`default_nettype wire

// ===== bench/nperm_checker.sv =====
`timescale 1ns / 1ps

module nperm_checker #(
   parameter int MAX_LEN = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    req_stall,
   input  wire nperm_pkg::req_word_type req_word,
   input  wire logic                    rsp_valid,
   input  wire logic                    rsp_stall,
   input  wire nperm_pkg::rsp_word_type rsp_word,
   output int unsigned                  mismatches,
   output int unsigned                  pending
);

   localparam int PRINT_CAP = 40;

   logic [7:0]              perm_store [MAX_LEN];
   int                      perm_len;
   int                      load_ptr;
   nperm_pkg::rsp_word_type due_words [$];
   int unsigned             fault_count = 0;

   assign mismatches = fault_count;

   task automatic report_mismatch(string what);
      if (fault_count < PRINT_CAP) begin
         $display("%0t ns: result mismatch: %s", $time, what);
      end
      fault_count++;
   endtask

   // in-place step to the next lexicographic order; 0 when none exists
   function automatic bit permute_forward(int n);
      int         k;
      int         l;
      int         i;
      int         j;
      logic [7:0] t;
      bit         found;
      found = 1'b0;
      k = 0;
      if (n < 2) return 1'b0;
      for (i = n - 1; i > 0; i--) begin
         if (perm_store[i - 1] < perm_store[i]) begin
            k = i - 1;
            found = 1'b1;
            break;
         end
      end
      if (!found) return 1'b0;
      l = k + 1;
      for (i = n - 1; i > k; i--) begin
         if (perm_store[k] < perm_store[i]) begin
            l = i;
            break;
         end
      end
      t = perm_store[k];
      perm_store[k] = perm_store[l];
      perm_store[l] = t;
      i = k + 1;
      j = n - 1;
      while (i < j) begin
         t = perm_store[i];
         perm_store[i] = perm_store[j];
         perm_store[j] = t;
         i++;
         j--;
      end
      return 1'b1;
   endfunction

   task automatic absorb_word(nperm_pkg::req_word_type w);
      int                      n;
      int                      i;
      nperm_pkg::rsp_word_type r;
      if (w.op == nperm_pkg::OP_LOAD) begin
         if (load_ptr < MAX_LEN) begin
            perm_store[load_ptr] = w.value;
            load_ptr++;
         end
         if (w.last) begin
            perm_len = load_ptr;
            load_ptr = 0;
         end
      end else begin
         n = (perm_len > MAX_LEN) ? MAX_LEN : perm_len;
         if (permute_forward(n)) begin
            for (i = 0; i < n; i++) begin
               r.elem       = perm_store[i];
               r.position   = i[3:0];
               r.end_of_run = (i == n - 1);
               r.done_res   = 1'b0;
               due_words.push_back(r);
            end
         end else begin
            r.elem       = 8'd0;
            r.position   = 4'd0;
            r.end_of_run = 1'b1;
            r.done_res   = 1'b1;
            due_words.push_back(r);
         end
      end
   endtask

   task automatic compare_word(nperm_pkg::rsp_word_type got);
      nperm_pkg::rsp_word_type want;
      if (due_words.size() == 0) begin
         report_mismatch($sformatf("word elem %0d pos %0d with nothing due",
                                   got.elem, got.position));
      end else begin
         want = due_words.pop_front();
         if (got.elem !== want.elem)
            report_mismatch($sformatf("elem %0d, want %0d (pos %0d)",
                                      got.elem, want.elem, want.position));
         if (got.position !== want.position)
            report_mismatch($sformatf("position %0d, want %0d", got.position, want.position));
         if (got.end_of_run !== want.end_of_run)
            report_mismatch($sformatf("end_of_run %0b, want %0b (pos %0d)",
                                      got.end_of_run, want.end_of_run, want.position));
         if (got.done_res !== want.done_res)
            report_mismatch($sformatf("done_res %0b, want %0b (pos %0d)",
                                      got.done_res, want.done_res, want.position));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         perm_len = 0;
         load_ptr = 0;
         due_words.delete();
      end else begin
         if (rsp_valid && !rsp_stall) compare_word(rsp_word);
         if (req_valid && !req_stall) absorb_word(req_word);
      end
      pending <= due_words.size();
   end

endmodule

// ===== bench/tb_next_permutation_generator.sv =====
`timescale 1ns / 1ps

module tb_next_permutation_generator;

   localparam int MAX_LEN       = 16;
   localparam int ITEM_TARGET   = 260;
   // an advance of sixteen runs its scans, swap and tail reverse before its first word moves; generous margin
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 120;

   logic                    clock     = 1'b0;
   logic                    reset     = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   nperm_pkg::req_word_type req_word  = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   nperm_pkg::rsp_word_type rsp_word;

   int unsigned  mismatches;
   int unsigned  pending;
   int unsigned  words_sent   = 0;
   int unsigned  quiet_cycles = 0;
   // calm: no idling on either side
   bit           calm         = 1'b0;

   always #6 clock = ~clock;

   next_permutation_generator #(
      .MAX_LEN    (MAX_LEN),
      .ELEM_WIDTH (8)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   nperm_checker #(
      .MAX_LEN (MAX_LEN)
   ) watch (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word),
      .mismatches (mismatches),
      .pending    (pending)
   );

   // receiver back-pressure: roughly a third of cycles stalled, none while calm
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < 33);
   end

   // watchdog: counts cycles in which no word moves on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // one word on the request channel; random idle gaps first unless calm
   task automatic send_word(logic op, logic [7:0] value, logic last);
      while (!calm && $urandom_range(0, 99) < 33) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= '{op: op, value: value, last: last};
      // stall is sampled as it stood before the edge
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   // value and last mean nothing on an advance, so they are randomised
   task automatic advance_word();
      send_word(nperm_pkg::OP_ADVANCE, 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
   endtask

   // narrow values give plenty of duplicates; close sets last on the final word
   task automatic load_run(int count, bit narrow, bit close);
      int i;
      for (i = 0; i < count; i++) begin
         send_word(nperm_pkg::OP_LOAD,
                   narrow ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255)),
                   close && (i == count - 1));
      end
   endtask

   // sender holds off until every predicted word has come back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   initial begin
      int len;
      int steps;
      int pick;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed ---
      advance_word();                              // nothing loaded yet: done straight away
      send_word(nperm_pkg::OP_LOAD, 8'hFF, 1'b1);  // length one
      advance_word();                              // length below two: done
      send_word(nperm_pkg::OP_LOAD, 8'h00, 1'b0);
      send_word(nperm_pkg::OP_LOAD, 8'hFF, 1'b1);
      advance_word();                              // 0,255 -> 255,0
      advance_word();                              // last ordering: done, store untouched
      send_word(nperm_pkg::OP_LOAD, 8'h01, 1'b0);
      send_word(nperm_pkg::OP_LOAD, 8'h01, 1'b0);
      send_word(nperm_pkg::OP_LOAD, 8'h02, 1'b1);
      advance_word();                              // duplicates: 1,1,2 -> 1,2,1
      advance_word();                              // -> 2,1,1
      send_word(nperm_pkg::OP_LOAD, 8'h55, 1'b0);  // unfinished load over the old entries
      send_word(nperm_pkg::OP_LOAD, 8'hAA, 1'b0);
      advance_word();                              // works on old length, pointer kept
      send_word(nperm_pkg::OP_LOAD, 8'h80, 1'b1);  // finishes the load at the kept pointer
      advance_word();
      drain();

      // --- random ---
      while (words_sent < ITEM_TARGET) begin
         // a long stretch with no idling on either side
         calm <= (words_sent >= 110) && (words_sent < 170);
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            // well-formed: complete load, then a walk of advances
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
               len = $urandom_range(1, 4);
            end else if (pick < 88) begin
               len = $urandom_range(5, MAX_LEN);
            end else begin
               len = $urandom_range(MAX_LEN + 1, MAX_LEN + 4);   // overruns capacity
            end
            load_run(len, 1'($urandom_range(0, 1)), 1'b1);
            steps = (len <= 4) ? $urandom_range(1, 8) : $urandom_range(1, 4);
            repeat (steps) advance_word();
         end else if (pick < 90) begin
            // broken: advance in the middle of a load
            load_run($urandom_range(1, 3), 1'($urandom_range(0, 1)), 1'b0);
            advance_word();
         end else begin
            advance_word();
         end
         if ($urandom_range(0, 99) < 6) drain();
      end

      calm <= 1'b0;
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/nperm_pkg.sv
hdl/nperm_ram.sv
hdl/next_permutation_generator.sv
bench/nperm_checker.sv
bench/tb_next_permutation_generator.sv
